>>> hdl/ipfc_pkg.sv
package ipfc_pkg;

    // Default table depth
    localparam int FLOW_ENTRIES_DEF = 64;

    // Frame layout
    localparam int MAC_BYTES      = 6;
    localparam int SRC_MAC_AT     = 6;
    localparam int SRC_IP_AT      = 26;
    localparam int DST_IP_AT      = 30;
    localparam int IP_BYTES       = 4;
    localparam int MIN_FRAME_LAST = 33;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int READ_IDX_W = 6;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int HITS_W     = 32;
    localparam int TOTAL_W    = 7;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 208;

    // Result kind, carried on tuser
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_EXISTING = 2'd1,
        ST_SHORT    = 2'd2,
        ST_FULL     = 2'd3
    } ipfc_status_t;

    // Addresses captured from the current frame
    typedef struct packed {
        logic [MAC_W-1:0] dst_mac;
        logic [MAC_W-1:0] src_mac;
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
    } ipfc_frame_t;

    // One flow table entry
    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [IP_W-1:0]   src_ip;
        logic [IP_W-1:0]   dst_ip;
        logic [HITS_W-1:0] hits;
    } ipfc_entry_t;

    localparam int ENTRY_W = $bits(ipfc_entry_t);

    // Result word, last member in the lowest bits
    typedef struct packed {
        logic [IP_W-1:0]       dst_ip;
        logic [IP_W-1:0]       src_ip;
        logic [MAC_W-1:0]      dst_mac;
        logic [MAC_W-1:0]      src_mac;
        logic [TOTAL_W-1:0]    flows_total;
        logic [HITS_W-1:0]     hit_count;
        logic [READ_IDX_W-1:0] entry_index;
        logic                  entry_valid;
        ipfc_status_t          status;
    } ipfc_result_t;

endpackage

>>> hdl/ipfc_ram.sv
module ipfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ipfc_parse.sv
module ipfc_parse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_we,
    input  logic [ipfc_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last_byte,
    output logic [ipfc_pkg::POS_W-1:0]  pos,
    output ipfc_pkg::ipfc_frame_t      frame
);

    import ipfc_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    ipfc_frame_t      frame_reg;
    ipfc_frame_t      frame_next;

    // Shift the byte into the field its position selects
    always_comb
    begin
        frame_next = frame_reg;
        if (pos_reg < POS_W'(MAC_BYTES))
        begin
            frame_next.dst_mac = {frame_reg.dst_mac[MAC_W-BYTE_W-1:0], data_byte};
        end
        else if (pos_reg < POS_W'(SRC_MAC_AT + MAC_BYTES))
        begin
            frame_next.src_mac = {frame_reg.src_mac[MAC_W-BYTE_W-1:0], data_byte};
        end
        else if (pos_reg >= POS_W'(SRC_IP_AT) && pos_reg < POS_W'(SRC_IP_AT + IP_BYTES))
        begin
            frame_next.src_ip = {frame_reg.src_ip[IP_W-BYTE_W-1:0], data_byte};
        end
        else if (pos_reg >= POS_W'(DST_IP_AT) && pos_reg < POS_W'(DST_IP_AT + IP_BYTES))
        begin
            frame_next.dst_ip = {frame_reg.dst_ip[IP_W-BYTE_W-1:0], data_byte};
        end
    end

    // Advance the position, saturate on long frames, restart after the last byte
    always_comb
    begin
        pos_next = pos_reg;
        if (byte_we)
        begin
            if (last_byte)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            frame_reg <= frame_next;
        end
    end

    assign pos   = pos_reg;
    assign frame = frame_reg;

endmodule

>>> hdl/ipfc_match.sv
module ipfc_match (
    input  ipfc_pkg::ipfc_entry_t           entry,
    input  ipfc_pkg::ipfc_frame_t           frame,
    output logic                            hit,
    output logic [ipfc_pkg::HITS_W-1:0]     hits_inc
);

    import ipfc_pkg::*;

    // Compare the IP pair of one entry against the frame
    assign hit = (entry.src_ip == frame.src_ip) && (entry.dst_ip == frame.dst_ip);

    // Saturating count increment
    assign hits_inc = (entry.hits == '1) ? entry.hits : entry.hits + HITS_W'(1);

endmodule

>>> hdl/ip_pair_flow_counter.sv
// Per IP pair frame counter with a flow table.
//
// Input stream (s_axis_*): one word per frame byte (tuser = 0, tlast on the
// final byte) or one readout request (tuser = 1, read index in tdata).
// Output stream (m_axis_*): one word per frame end and per readout request;
// tuser tells a frame outcome (0) from an entry readout (1).
//
// A frame byte that is not the last keeps the sequencer in S_IDLE, so bytes
// stream at one word per clock. At the last byte the stored flows are walked
// one entry per cycle through a single compare and count unit on the table's
// read port (S_CMP), then S_MISS on a miss; a short frame goes straight to
// S_PUT, a readout of a stored entry through S_READ. S_PUT moves the result
// into the output register. s_axis_tready is low during that walk and while
// a result waits to move into the output register.
//
// The output register holds one word; while it waits on m_axis_tready the
// block keeps accepting frame bytes, and stops at the next word that needs a
// result. Reset empties the table and the frame parser; the table memory is
// not cleared, since only entries below the fill count are ever used.
module ip_pair_flow_counter #(
    parameter int FLOW_ENTRIES = ipfc_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // [7:0] data_byte, [13:8] read_index, [15:14] zero
    input  logic [ipfc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] status, [2] entry_valid, [8:3] entry_index, [40:9] hit_count,
    // [47:41] flows_total, [95:48] entry_src_mac, [143:96] entry_dst_mac,
    // [175:144] entry_src_ip, [207:176] entry_dst_ip
    output logic [ipfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] result_kind
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    import ipfc_pkg::*;

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FLOW_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS,
        S_PUT
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [CNT_W-1:0]        flows_used_reg;
    logic [CNT_W-1:0]        flows_used_next;
    ipfc_result_t            res_reg;
    ipfc_result_t            res_next;
    logic                    res_kind_reg;
    logic                    res_kind_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic                    m_tuser_reg;
    logic                    m_tuser_next;
    ipfc_result_t            m_tdata_reg;
    ipfc_result_t            m_tdata_next;

    logic                    in_accept;
    logic                    in_kind;
    logic [BYTE_W-1:0]       in_byte;
    logic [READ_IDX_W-1:0]   in_ridx;
    logic                    byte_we;
    logic [POS_W-1:0]        pos;
    ipfc_frame_t             frame;
    logic                    rd_ok;
    logic                    walk_last;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    ipfc_entry_t             ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    ipfc_entry_t             rd_entry;
    logic                    match_hit;
    logic [HITS_W-1:0]       match_hits_inc;

    // Unpack the input word
    assign in_kind   = s_axis_tuser;
    assign in_byte   = s_axis_tdata[BYTE_W-1:0];
    assign in_ridx   = s_axis_tdata[BYTE_W +: READ_IDX_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign byte_we   = in_accept && (in_kind == KIND_FRAME);

    assign s_axis_tready = (state_reg == S_IDLE);

    ipfc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_we   (byte_we),
        .data_byte (in_byte),
        .last_byte (s_axis_tlast),
        .pos       (pos),
        .frame     (frame)
    );

    ipfc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = ipfc_entry_t'(ram_rdata);

    ipfc_match u_match (
        .entry    (rd_entry),
        .frame    (frame),
        .hit      (match_hit),
        .hits_inc (match_hits_inc)
    );

    assign rd_ok     = CMP_W'(in_ridx) < CMP_W'(flows_used_reg);
    assign walk_last = (CNT_W'(idx_reg) + CNT_W'(1)) == flows_used_reg;

    // Sequencer: capture, read out or walk the table, update or append, hand off the result
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        flows_used_next = flows_used_reg;
        res_next        = res_reg;
        res_kind_next   = res_kind_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rd_entry;
        ram_raddr       = idx_reg + IDX_W'(1);

        // Drop the output word once taken
        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (in_kind == KIND_READ) ? IDX_W'(in_ridx) : '0;
                if (in_accept)
                begin
                    res_next             = '0;
                    res_next.status      = ST_NEW;
                    res_kind_next        = in_kind;
                    if (in_kind == KIND_READ)
                    begin
                        res_next.entry_index = in_ridx;
                        if (rd_ok)
                        begin
                            idx_next   = IDX_W'(in_ridx);
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    else if (s_axis_tlast)
                    begin
                        if (pos < POS_W'(MIN_FRAME_LAST))
                        begin
                            res_next.status = ST_SHORT;
                            state_next      = S_PUT;
                        end
                        else if (flows_used_reg == '0)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_CMP;
                        end
                    end
                end
            end

            S_READ:
            begin
                res_next.entry_valid = 1'b1;
                res_next.hit_count   = rd_entry.hits;
                res_next.src_mac     = rd_entry.src_mac;
                res_next.dst_mac     = rd_entry.dst_mac;
                res_next.src_ip      = rd_entry.src_ip;
                res_next.dst_ip      = rd_entry.dst_ip;
                state_next           = S_PUT;
            end

            S_CMP:
            begin
                if (match_hit)
                begin
                    ram_we               = 1'b1;
                    ram_wdata.hits       = match_hits_inc;
                    res_next.status      = ST_EXISTING;
                    res_next.entry_valid = 1'b1;
                    res_next.entry_index = READ_IDX_W'(idx_reg);
                    res_next.hit_count   = match_hits_inc;
                    res_next.src_mac     = rd_entry.src_mac;
                    res_next.dst_mac     = rd_entry.dst_mac;
                    res_next.src_ip      = rd_entry.src_ip;
                    res_next.dst_ip      = rd_entry.dst_ip;
                    state_next           = S_PUT;
                end
                else if (walk_last)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_MISS:
            begin
                res_next.src_mac = frame.src_mac;
                res_next.dst_mac = frame.dst_mac;
                res_next.src_ip  = frame.src_ip;
                res_next.dst_ip  = frame.dst_ip;
                if (flows_used_reg == CNT_FULL)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = IDX_W'(flows_used_reg);
                    ram_wdata.src_mac    = frame.src_mac;
                    ram_wdata.dst_mac    = frame.dst_mac;
                    ram_wdata.src_ip     = frame.src_ip;
                    ram_wdata.dst_ip     = frame.dst_ip;
                    ram_wdata.hits       = HITS_W'(1);
                    flows_used_next      = flows_used_reg + CNT_W'(1);
                    res_next.status      = ST_NEW;
                    res_next.entry_valid = 1'b1;
                    res_next.entry_index = READ_IDX_W'(flows_used_reg);
                    res_next.hit_count   = HITS_W'(1);
                end
                state_next = S_PUT;
            end

            S_PUT:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next            = 1'b1;
                    m_tuser_next             = res_kind_reg;
                    m_tdata_next             = res_reg;
                    m_tdata_next.flows_total = TOTAL_W'(flows_used_reg);
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            flows_used_reg <= '0;
            res_reg        <= '0;
            res_kind_reg   <= KIND_FRAME;
            m_tvalid_reg   <= 1'b0;
            m_tuser_reg    <= KIND_FRAME;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            flows_used_reg <= flows_used_next;
            res_reg        <= res_next;
            res_kind_reg   <= res_kind_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tuser_reg    <= m_tuser_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

>>> hdl/ipfc_checker.sv
module ipfc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ipfc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [ipfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    import ipfc_pkg::*;

    ipfc_result_t res;

    assign res = ipfc_result_t'(m_axis_tdata);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // A word that needs a result closes the input in the cycle after it is accepted
    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_READ || s_axis_tlast) |=>
            !s_axis_tready)
        else $error("input accepted during table access");

    // Readouts always carry the zero status code
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_READ |-> res.status == ST_NEW)
        else $error("readout with frame status");

    // Short and dropped frames describe no entry
    a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FRAME &&
            (res.status == ST_SHORT || res.status == ST_FULL) |->
            !res.entry_valid && res.hit_count == '0 && res.entry_index == '0)
        else $error("entry fields set on a frame without entry");

    // A stored entry has been hit at least once
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.entry_valid |-> res.hit_count != '0)
        else $error("valid entry with zero count");

endmodule

bind ip_pair_flow_counter ipfc_checker u_ipfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1580;
    localparam int TAIL_CYCLES    = 80;

    // One expected word on the master side
    typedef struct {
        logic         kind;
        ipfc_result_t word;
    } flow_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // Predicted parser and flow table state
    int                byte_pos;
    logic [MAC_W-1:0]  cur_dst_mac;
    logic [MAC_W-1:0]  cur_src_mac;
    logic [IP_W-1:0]   cur_src_ip;
    logic [IP_W-1:0]   cur_dst_ip;
    logic [IP_W-1:0]   tbl_src_ip  [FLOW_ENTRIES_DEF];
    logic [IP_W-1:0]   tbl_dst_ip  [FLOW_ENTRIES_DEF];
    logic [MAC_W-1:0]  tbl_src_mac [FLOW_ENTRIES_DEF];
    logic [MAC_W-1:0]  tbl_dst_mac [FLOW_ENTRIES_DEF];
    logic [HITS_W-1:0] tbl_hits    [FLOW_ENTRIES_DEF];
    int                flows_stored;

    flow_result_t pending_results[$];

    // Run statistics
    int fail_count;
    int words_sent;
    int frames_sent;
    int new_cnt;
    int hit_cnt;
    int short_cnt;
    int drop_cnt;
    int read_cnt;

    // Idling control
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold;
    int rx_mode_left;
    int quiet_cycles;

    ip_pair_flow_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Compute the word the block owes for one accepted input word
    task automatic predict_word(input logic kind, input logic [7:0] b, input logic last,
                                input logic [READ_IDX_W-1:0] ridx);
        flow_result_t r;
        int           p;
        int           i;
        r.kind = kind;
        r.word = '0;
        // Table readout
        if (kind == KIND_READ)
        begin
            r.word.status      = ST_NEW;
            r.word.entry_index = ridx;
            r.word.flows_total = TOTAL_W'(flows_stored);
            if (int'(ridx) < flows_stored)
            begin
                r.word.entry_valid = 1'b1;
                r.word.hit_count   = tbl_hits[ridx];
                r.word.src_mac     = tbl_src_mac[ridx];
                r.word.dst_mac     = tbl_dst_mac[ridx];
                r.word.src_ip      = tbl_src_ip[ridx];
                r.word.dst_ip      = tbl_dst_ip[ridx];
            end
            read_cnt++;
            pending_results.push_back(r);
            return;
        end
        // Capture address bytes
        p = byte_pos;
        if (p < MAC_BYTES)
            cur_dst_mac = {cur_dst_mac[MAC_W-9:0], b};
        else if (p < SRC_MAC_AT + MAC_BYTES)
            cur_src_mac = {cur_src_mac[MAC_W-9:0], b};
        else if (p >= SRC_IP_AT && p < SRC_IP_AT + IP_BYTES)
            cur_src_ip = {cur_src_ip[IP_W-9:0], b};
        else if (p >= DST_IP_AT && p < DST_IP_AT + IP_BYTES)
            cur_dst_ip = {cur_dst_ip[IP_W-9:0], b};
        if (byte_pos < 63)
            byte_pos++;
        if (!last)
            return;
        byte_pos = 0;
        r.word.flows_total = TOTAL_W'(flows_stored);
        // Short frame: ignored
        if (p < MIN_FRAME_LAST)
        begin
            r.word.status = ST_SHORT;
            short_cnt++;
            pending_results.push_back(r);
            return;
        end
        // Walk the table for the IP pair
        for (i = 0; i < flows_stored; i++)
        begin
            if (tbl_src_ip[i] == cur_src_ip && tbl_dst_ip[i] == cur_dst_ip)
            begin
                if (tbl_hits[i] != '1)
                    tbl_hits[i]++;
                r.word.status      = ST_EXISTING;
                r.word.entry_valid = 1'b1;
                r.word.entry_index = READ_IDX_W'(i);
                r.word.hit_count   = tbl_hits[i];
                r.word.src_mac     = tbl_src_mac[i];
                r.word.dst_mac     = tbl_dst_mac[i];
                r.word.src_ip      = tbl_src_ip[i];
                r.word.dst_ip      = tbl_dst_ip[i];
                hit_cnt++;
                pending_results.push_back(r);
                return;
            end
        end
        r.word.src_mac = cur_src_mac;
        r.word.dst_mac = cur_dst_mac;
        r.word.src_ip  = cur_src_ip;
        r.word.dst_ip  = cur_dst_ip;
        // Table full: drop the flow
        if (flows_stored >= FLOW_ENTRIES_DEF)
        begin
            r.word.status = ST_FULL;
            drop_cnt++;
            pending_results.push_back(r);
            return;
        end
        // Miss: append a new entry
        i = flows_stored;
        tbl_src_ip[i]  = cur_src_ip;
        tbl_dst_ip[i]  = cur_dst_ip;
        tbl_src_mac[i] = cur_src_mac;
        tbl_dst_mac[i] = cur_dst_mac;
        tbl_hits[i]    = HITS_W'(1);
        flows_stored++;
        r.word.status      = ST_NEW;
        r.word.entry_valid = 1'b1;
        r.word.entry_index = READ_IDX_W'(i);
        r.word.hit_count   = HITS_W'(1);
        r.word.flows_total = TOTAL_W'(flows_stored);
        new_cnt++;
        pending_results.push_back(r);
    endtask

    // Drive one word and hold it until the block takes it
    task automatic send_word(input logic kind, input logic [7:0] b, input logic last,
                             input logic [READ_IDX_W-1:0] ridx);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 35)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {2'b00, ridx, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        predict_word(kind, b, last, ridx);
    endtask

    // Readout word; the frame byte and last flag carry noise
    task automatic send_read(input logic [READ_IDX_W-1:0] ridx);
        send_word(KIND_READ, 8'($urandom), 1'($urandom), ridx);
    endtask

    // Send one frame, optionally with readouts slipped in between its bytes
    task automatic send_frame(input logic [MAC_W-1:0] dmac, input logic [MAC_W-1:0] smac,
                              input logic [IP_W-1:0] sip, input logic [IP_W-1:0] dip,
                              input int len, input int read_pct);
        logic [7:0] b;
        for (int p = 0; p < len; p++)
        begin
            if (p > 0 && $urandom_range(0, 99) < read_pct)
                send_read(READ_IDX_W'($urandom));
            if (p < MAC_BYTES)
                b = dmac[MAC_W-1-8*p -: 8];
            else if (p < SRC_MAC_AT + MAC_BYTES)
                b = smac[MAC_W-1-8*(p-SRC_MAC_AT) -: 8];
            else if (p >= SRC_IP_AT && p < SRC_IP_AT + IP_BYTES)
                b = sip[IP_W-1-8*(p-SRC_IP_AT) -: 8];
            else if (p >= DST_IP_AT && p < DST_IP_AT + IP_BYTES)
                b = dip[IP_W-1-8*(p-DST_IP_AT) -: 8];
            else
                b = 8'($urandom);
            send_word(KIND_FRAME, b, p == len - 1, READ_IDX_W'($urandom));
        end
        frames_sent++;
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    // Hold the sender until every owed word has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Empty table and short frames
    task automatic test_short_and_empty();
        send_read('0);
        send_read('1);
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, 1, 0);
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, MIN_FRAME_LAST, 0);
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, 2, 0);
    endtask

    // Inserts, hits on either match, partial IP matches, long frame
    task automatic test_insert_and_hit();
        send_frame('0, '0, '0, '0, MIN_FRAME_LAST + 1, 0);
        send_frame('1, '1, '1, '1, MIN_FRAME_LAST + 1, 0);
        send_frame(rand_mac(), rand_mac(), '1, '1, MIN_FRAME_LAST + 1, 0);
        send_frame(rand_mac(), rand_mac(), '0, '0, 90, 0);
        send_frame(rand_mac(), rand_mac(), '1, '0, MIN_FRAME_LAST + 1, 0);
        send_frame(rand_mac(), rand_mac(), '0, '1, MIN_FRAME_LAST + 2, 0);
        for (int i = 0; i < 5; i++)
            send_read(READ_IDX_W'(i));
    endtask

    // Readouts interleaved with frame bytes
    task automatic test_read_during_frame();
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, 40, 30);
        send_frame(rand_mac(), rand_mac(), tbl_src_ip[0], tbl_dst_ip[0], 36, 20);
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, 12, 40);
    endtask

    // Sender waits until the output side has caught up
    task automatic test_drain_pause();
        send_frame(rand_mac(), rand_mac(), $urandom, $urandom, MIN_FRAME_LAST + 1, 0);
        wait_for_results();
        send_read(READ_IDX_W'($urandom_range(0, flows_stored - 1)));
        wait_for_results();
    endtask

    // Random mix of new flows, repeated flows, short frames and readouts
    task automatic test_random_traffic();
        int               sel;
        int               len;
        int               idx;
        int               new_pct;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  dip;
        while (words_sent < RANDOM_WORDS)
        begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                // broken frame: too short
                send_frame(rand_mac(), rand_mac(), $urandom, $urandom,
                           $urandom_range(1, MIN_FRAME_LAST), 10);
            end
            else if (sel < 18)
            begin
                repeat ($urandom_range(1, 4))
                    send_read(READ_IDX_W'($urandom));
            end
            else if (sel < 20)
            begin
                wait_for_results();
            end
            else
            begin
                new_pct = (flows_stored < FLOW_ENTRIES_DEF) ? 75 : 30;
                sip = $urandom;
                dip = $urandom;
                if (flows_stored > 0 && $urandom_range(0, 99) >= new_pct)
                begin
                    idx = $urandom_range(0, flows_stored - 1);
                    sip = tbl_src_ip[idx];
                    dip = tbl_dst_ip[idx];
                end
                sel = $urandom_range(0, 99);
                if (sel < 85)
                    len = $urandom_range(MIN_FRAME_LAST + 1, 40);
                else if (sel < 95)
                    len = $urandom_range(41, 62);
                else
                    len = $urandom_range(63, 90);
                send_frame(rand_mac(), rand_mac(), sip, dip, len,
                           ($urandom_range(0, 99) < 15) ? 5 : 0);
            end
        end
        tx_idle_on = 1'b1;
    endtask

    // Read back every table slot, used or not
    task automatic test_full_table_readback();
        for (int i = 0; i < FLOW_ENTRIES_DEF; i++)
            send_read(READ_IDX_W'(i));
    endtask

    // Stall the master side at random, with stretches of no stalls
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_idle_on   = $urandom_range(0, 3) != 0;
            rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 9) < 3)
        begin
            rx_hold = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each output word against the oldest prediction
    always @(posedge clk)
    begin : result_check
        flow_result_t want;
        ipfc_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = ipfc_result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                $error("unexpected output word %0h, tuser %0b", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(m_axis_tuser));
                check_field("status", 64'(want.word.status), 64'(got.status));
                check_field("entry_valid", 64'(want.word.entry_valid), 64'(got.entry_valid));
                check_field("entry_index", 64'(want.word.entry_index), 64'(got.entry_index));
                check_field("hit_count", 64'(want.word.hit_count), 64'(got.hit_count));
                check_field("flows_total", 64'(want.word.flows_total), 64'(got.flows_total));
                check_field("entry_src_mac", 64'(want.word.src_mac), 64'(got.src_mac));
                check_field("entry_dst_mac", 64'(want.word.dst_mac), 64'(got.dst_mac));
                check_field("entry_src_ip", 64'(want.word.src_ip), 64'(got.src_ip));
                check_field("entry_dst_ip", 64'(want.word.dst_ip), 64'(got.dst_ip));
            end
        end
    end

    // End the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no word accepted for %0d cycles, %0d words owed",
                       quiet_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        byte_pos     = 0;
        cur_dst_mac  = '0;
        cur_src_mac  = '0;
        cur_src_ip   = '0;
        cur_dst_ip   = '0;
        flows_stored = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_and_empty();
        test_insert_and_hit();
        test_read_during_frame();
        test_drain_pause();
        test_random_traffic();
        test_full_table_readback();

        // Drain and let the block settle
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d frames with %0d readouts; table holds %0d flows.",
                 words_sent, frames_sent, read_cnt, flows_stored);
        $display("Frame outcomes: %0d new, %0d existing, %0d short, %0d dropped when full.",
                 new_cnt, hit_cnt, short_cnt, drop_cnt);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
